[rtl/tnu_pkg.sv]
package tnu_pkg;

  localparam int CoordBits    = 16;
  localparam int NormFracBits = 14;

  localparam int EdgeBits  = CoordBits + 1;
  localparam int ProdBits  = 2 * EdgeBits;
  localparam int CrossBits = ProdBits + 1;
  localparam int MagBits   = CrossBits - 1;
  localparam int HalfBits  = (MagBits + 1) / 2;
  localparam int HighBits  = MagBits - HalfBits;
  localparam int SqBits    = 2 * MagBits;
  localparam int SumBits   = 2 * MagBits + 2;
  localparam int RootBits  = SumBits / 2;
  localparam int RemBits   = RootBits + 3;
  localparam int OutBits   = NormFracBits + 2;

  typedef struct packed {
    logic signed [CoordBits-1:0] a_x;
    logic signed [CoordBits-1:0] a_y;
    logic signed [CoordBits-1:0] a_z;
    logic signed [CoordBits-1:0] b_x;
    logic signed [CoordBits-1:0] b_y;
    logic signed [CoordBits-1:0] b_z;
    logic signed [CoordBits-1:0] c_x;
    logic signed [CoordBits-1:0] c_y;
    logic signed [CoordBits-1:0] c_z;
  } tri_t;

  typedef struct packed {
    logic signed [OutBits-1:0] normal_x;
    logic signed [OutBits-1:0] normal_y;
    logic signed [OutBits-1:0] normal_z;
    logic                      degenerate;
  } normal_t;

  typedef struct packed {
    logic [RemBits-1:0]  rem;
    logic [RootBits-1:0] root;
    logic [SumBits-1:0]  sum;
  } isqrt_t;

  typedef struct packed {
    logic [RootBits-1:0]     r;
    logic [NormFracBits-1:0] q;
    logic                    sat;
    logic                    neg;
  } div_t;

endpackage

[rtl/tnu_isqrt_cell.sv]
module tnu_isqrt_cell (
  input  logic            clk_i,
  input  logic            en_i,
  input  tnu_pkg::isqrt_t in_i,
  output tnu_pkg::isqrt_t out_o
);

  localparam int RemBits  = tnu_pkg::RemBits;
  localparam int RootBits = tnu_pkg::RootBits;
  localparam int SumBits  = tnu_pkg::SumBits;

  logic [RemBits-1:0] rem_sh;
  logic [RemBits-1:0] trial;
  logic               ge;
  tnu_pkg::isqrt_t    cell_d, cell_q;

  always_comb begin
    rem_sh = {in_i.rem[RemBits-3:0], in_i.sum[SumBits-1 -: 2]};
    trial  = RemBits'({in_i.root, 2'b01});
    ge     = rem_sh >= trial;
    cell_d.rem  = ge ? rem_sh - trial : rem_sh;
    cell_d.root = {in_i.root[RootBits-2:0], ge};
    cell_d.sum  = {in_i.sum[SumBits-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign out_o = cell_q;

endmodule

[rtl/tnu_div_cell.sv]
module tnu_div_cell (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [tnu_pkg::RootBits-1:0] len_i,
  input  tnu_pkg::div_t                in_i,
  output tnu_pkg::div_t                out_o
);

  localparam int RootBits = tnu_pkg::RootBits;
  localparam int FracBits = tnu_pkg::NormFracBits;

  logic [RootBits:0] r_sh;
  logic              ge;
  tnu_pkg::div_t     cell_d, cell_q;

  always_comb begin
    r_sh = {in_i.r, 1'b0};
    ge   = r_sh >= {1'b0, len_i};
    cell_d     = in_i;
    cell_d.r   = ge ? RootBits'(r_sh - {1'b0, len_i}) : RootBits'(r_sh);
    cell_d.q   = {in_i.q[FracBits-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign out_o = cell_q;

endmodule

[rtl/triangle_normal_unit_core.sv]
// Triangle face normal unit.
// Input channel in_valid_i / in_stall_o carries one triangle (three vertices,
// signed fixed point) per transaction. Output channel out_valid_o / out_stall_i
// carries the unit normal (Q1.14 per component) and a degenerate flag, set
// with a zero normal when the cross product is zero.
// One transaction is accepted per cycle while the output is not stalled.
// The pipeline runs through stages of edge, cross product and square-sum
// arithmetic, then a chain of square-root cells resolving one root bit per cell,
// then one chain of divider cells per component producing one quotient bit
// per cell, then the output register.
// Every cell passes its work to its neighbor each cycle unless the chain holds,
// so throughput is one transaction per cycle while the output is not stalled.
// When the output register holds a result and out_stall_i is high, the whole
// chain holds and in_stall_o is raised in the same cycle.
// Reset clears all valid flags; data registers are not reset.
module triangle_normal_unit_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tnu_pkg::tri_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output tnu_pkg::normal_t out_data_o
);

  localparam int EdgeBits  = tnu_pkg::EdgeBits;
  localparam int ProdBits  = tnu_pkg::ProdBits;
  localparam int CrossBits = tnu_pkg::CrossBits;
  localparam int MagBits   = tnu_pkg::MagBits;
  localparam int HalfBits  = tnu_pkg::HalfBits;
  localparam int HighBits  = tnu_pkg::HighBits;
  localparam int SqBits    = tnu_pkg::SqBits;
  localparam int SumBits   = tnu_pkg::SumBits;
  localparam int RootBits  = tnu_pkg::RootBits;
  localparam int FracBits  = tnu_pkg::NormFracBits;
  localparam int OutBits   = tnu_pkg::OutBits;
  localparam int NumStg    = 4 + RootBits + FracBits;

  logic en;
  logic [NumStg-1:0] vld_q;
  logic              out_valid_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign en         = ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[NumStg-2:0], in_valid_i};
      out_valid_q <= vld_q[NumStg-1];
    end
  end

  // stage 1: edges and cross partial products
  logic signed [EdgeBits-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [ProdBits-1:0] p_d [6];
  logic signed [ProdBits-1:0] p_q [6];

  always_comb begin
    e1x = EdgeBits'(in_data_i.b_x) - EdgeBits'(in_data_i.a_x);
    e1y = EdgeBits'(in_data_i.b_y) - EdgeBits'(in_data_i.a_y);
    e1z = EdgeBits'(in_data_i.b_z) - EdgeBits'(in_data_i.a_z);
    e2x = EdgeBits'(in_data_i.c_x) - EdgeBits'(in_data_i.a_x);
    e2y = EdgeBits'(in_data_i.c_y) - EdgeBits'(in_data_i.a_y);
    e2z = EdgeBits'(in_data_i.c_z) - EdgeBits'(in_data_i.a_z);
    p_d[0] = ProdBits'(e1y) * ProdBits'(e2z);
    p_d[1] = ProdBits'(e1z) * ProdBits'(e2y);
    p_d[2] = ProdBits'(e1z) * ProdBits'(e2x);
    p_d[3] = ProdBits'(e1x) * ProdBits'(e2z);
    p_d[4] = ProdBits'(e1x) * ProdBits'(e2y);
    p_d[5] = ProdBits'(e1y) * ProdBits'(e2x);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q <= p_d;
    end
  end

  // stage 2: cross product magnitude and sign
  logic signed [CrossBits-1:0] n_c [3];
  logic [MagBits-1:0] mag2_q [3];
  logic [2:0]         neg2_q;
  logic               deg2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_c[i] = CrossBits'(p_q[2*i]) - CrossBits'(p_q[2*i+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag2_q[i] <= n_c[i][CrossBits-1] ? MagBits'(-n_c[i]) : MagBits'(n_c[i]);
        neg2_q[i] <= n_c[i][CrossBits-1];
      end
      deg2_q <= (n_c[0] == '0) && (n_c[1] == '0) && (n_c[2] == '0);
    end
  end

  // stage 3: split squares
  logic [2*HighBits-1:0]         hh_q [3];
  logic [HighBits+HalfBits-1:0]  hl_q [3];
  logic [2*HalfBits-1:0]         ll_q [3];
  logic [MagBits-1:0] mag3_q [3];
  logic [2:0]         neg3_q;
  logic               deg3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hh_q[i] <= (2*HighBits)'(mag2_q[i][MagBits-1:HalfBits])
                 * (2*HighBits)'(mag2_q[i][MagBits-1:HalfBits]);
        hl_q[i] <= (HighBits+HalfBits)'(mag2_q[i][MagBits-1:HalfBits])
                 * (HighBits+HalfBits)'(mag2_q[i][HalfBits-1:0]);
        ll_q[i] <= (2*HalfBits)'(mag2_q[i][HalfBits-1:0])
                 * (2*HalfBits)'(mag2_q[i][HalfBits-1:0]);
      end
      mag3_q <= mag2_q;
      neg3_q <= neg2_q;
      deg3_q <= deg2_q;
    end
  end

  // stage 4: sum of squares
  logic [SqBits-1:0]  sq_c [3];
  logic [SumBits-1:0] sum4_q;
  logic [MagBits-1:0] mag4_q [3];
  logic [2:0]         neg4_q;
  logic               deg4_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_c[i] = (SqBits'(hh_q[i]) << (2*HalfBits)) + (SqBits'(hl_q[i]) << (HalfBits+1))
              + SqBits'(ll_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum4_q <= SumBits'(sq_c[0]) + SumBits'(sq_c[1]) + SumBits'(sq_c[2]);
      mag4_q <= mag3_q;
      neg4_q <= neg3_q;
      deg4_q <= deg3_q;
    end
  end

  // square root chain
  tnu_pkg::isqrt_t sq_link [RootBits+1];
  logic [MagBits-1:0] mag_sh_q [RootBits][3];
  logic [2:0]         neg_sh_q [RootBits];
  logic               deg_sh_q [RootBits];

  always_comb begin
    sq_link[0].rem  = '0;
    sq_link[0].root = '0;
    sq_link[0].sum  = sum4_q;
  end

  for (genvar k = 0; k < RootBits; k++) begin : g_sqrt
    tnu_isqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .in_i  (sq_link[k]),
      .out_o (sq_link[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_sh_q[0] <= mag4_q;
      neg_sh_q[0] <= neg4_q;
      deg_sh_q[0] <= deg4_q;
      for (int k = 1; k < RootBits; k++) begin
        mag_sh_q[k] <= mag_sh_q[k-1];
        neg_sh_q[k] <= neg_sh_q[k-1];
        deg_sh_q[k] <= deg_sh_q[k-1];
      end
    end
  end

  // divider chains, one per component
  logic [RootBits-1:0] len;
  logic [RootBits-1:0] len_sh_q [FracBits];
  logic                deg_dv_q [FracBits];
  tnu_pkg::div_t       dv_link [3][FracBits+1];

  assign len = sq_link[RootBits].root;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign dv_link[i][0].sat = RootBits'(mag_sh_q[RootBits-1][i]) >= len;
    assign dv_link[i][0].r   = dv_link[i][0].sat ? '0 : RootBits'(mag_sh_q[RootBits-1][i]);
    assign dv_link[i][0].q   = '0;
    assign dv_link[i][0].neg = neg_sh_q[RootBits-1][i];

    for (genvar k = 0; k < FracBits; k++) begin : g_div
      tnu_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .len_i ((k == 0) ? len : len_sh_q[(k == 0) ? 0 : k-1]),
        .in_i  (dv_link[i][k]),
        .out_o (dv_link[i][k+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      len_sh_q[0] <= len;
      deg_dv_q[0] <= deg_sh_q[RootBits-1];
      for (int k = 1; k < FracBits; k++) begin
        len_sh_q[k] <= len_sh_q[k-1];
        deg_dv_q[k] <= deg_dv_q[k-1];
      end
    end
  end

  // output register
  logic [OutBits-1:0] comp_c [3];
  tnu_pkg::normal_t   out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      comp_c[i] = dv_link[i][FracBits].sat ? (OutBits'(1) << FracBits)
                                           : OutBits'(dv_link[i][FracBits].q);
      if (dv_link[i][FracBits].neg) begin
        comp_c[i] = -comp_c[i];
      end
      if (deg_dv_q[FracBits-1]) begin
        comp_c[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.normal_x   <= comp_c[0];
      out_q.normal_y   <= comp_c[1];
      out_q.normal_z   <= comp_c[2];
      out_q.degenerate <= deg_dv_q[FracBits-1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  localparam logic signed [OutBits-1:0] One = OutBits'(1) << FracBits;

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.normal_x == '0 && out_data_o.normal_y == '0 && out_data_o.normal_z == '0)
    else $error("degenerate result with nonzero normal");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.normal_x <= One && out_data_o.normal_x >= -One &&
      out_data_o.normal_y <= One && out_data_o.normal_y >= -One &&
      out_data_o.normal_z <= One && out_data_o.normal_z >= -One)
    else $error("normal component out of range");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld_q[0])
    else $error("accepted transaction lost at pipeline entry");

endmodule
